// File: hdl/rtf_pkg.sv
// Shared types, constants and helpers for the radix integer text formatter.
package rtf_pkg;

  localparam int MAX_WIDTH_DEF = 48;

  localparam int VAL_W      = 32;
  localparam int STEP_W     = $clog2(VAL_W);
  localparam int RADIX_W    = 6;
  localparam int CHAR_W     = 8;
  localparam int FW_W       = 7;
  localparam int DIGITS_MAX = 32;
  localparam int DIG_W      = $clog2(DIGITS_MAX + 1);

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

  localparam logic [1:0] REG_RADIX = 2'd0;
  localparam logic [1:0] REG_LOWER = 2'd1;
  localparam logic [1:0] REG_WIDTH = 2'd2;
  localparam logic [1:0] REG_PAD   = 2'd3;

  localparam logic [CHAR_W-1:0] CH_ZERO       = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CH_UPPER_BASE = 8'h37;  // 'A' - 10
  localparam logic [CHAR_W-1:0] CH_LOWER_BASE = 8'h57;  // 'a' - 10
  localparam logic [CHAR_W-1:0] CH_MINUS      = 8'h2D;  // '-'
  localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic push;
    logic pop;
  } lifo_ctrl_t;

  typedef struct packed {
    logic               done;
    logic [VAL_W-1:0]   quot;
    logic [RADIX_W-1:0] rem;
  } div_out_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d,
                                                   input logic lc);
    logic [CHAR_W-1:0] base;
    begin
      if (d < 6'd10) begin
        base = CH_ZERO;
      end else if (lc) begin
        base = CH_LOWER_BASE;
      end else begin
        base = CH_UPPER_BASE;
      end
      digit_char = base + {2'b00, d};
    end
  endfunction

endpackage

// File: hdl/rtf_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module rtf_div
  import rtf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [VAL_W-1:0]   dividend,
  input  logic [RADIX_W-1:0] base,
  output div_out_t           res
);

  logic [VAL_W-1:0]  dvd;
  logic [RADIX_W:0]  rem;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic              done;

  logic [RADIX_W:0]  trial;
  logic [RADIX_W:0]  diff;
  logic              ge;

  always_comb begin
    trial = {rem[RADIX_W-1:0], dvd[VAL_W-1]};
    ge    = trial >= {1'b0, base};
    diff  = trial - {1'b0, base};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(VAL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift into the dividend register from the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[VAL_W-2:0], ge};
      rem <= ge ? diff : trial;
    end
  end

  assign res = '{done: done, quot: dvd, rem: rem[RADIX_W-1:0]};

endmodule

// File: hdl/rtf_lifo.sv
// Shift-register digit stack: digits pushed least significant first, popped most first.
module rtf_lifo
  import rtf_pkg::*;
(
  input  logic              clk,
  input  lifo_ctrl_t        ctrl,
  input  logic [CHAR_W-1:0] din,
  output logic [CHAR_W-1:0] top
);

  logic [CHAR_W-1:0] stk [DIGITS_MAX];

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      stk[0] <= din;
      for (int i = 1; i < DIGITS_MAX; i++) begin
        stk[i] <= stk[i-1];
      end
    end else if (ctrl.pop) begin
      for (int i = 0; i < DIGITS_MAX - 1; i++) begin
        stk[i] <= stk[i+1];
      end
    end
  end

  assign top = stk[0];

endmodule

// File: hdl/radix_integer_text_formatter.sv
// Top level: config registers, sequencer and output register of the text formatter.
//
//   port group   dir  payload                          handshake
//   s_*          in   tdata: value[31:0]; tuser: mode  s_tvalid & s_tready
//   m_*          out  tdata: out_char[7:0]; tlast      m_tvalid & m_tready
//   cfg_*        in   index 0..3, wdata[7:0]           cfg_we
//
// An item is converted as D digits, each from a 32-step bit-serial divide (one
// quotient bit per cycle), then T characters go out at one per cycle while the
// output is not stalled, through the single output register.
// Input is taken only while the sequencer is idle; the last character may still wait.
// A stalled output holds the sequencer in emit. Reset is synchronous, active high.
module radix_integer_text_formatter
  import rtf_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [VAL_W-1:0]  s_tdata,    // value[31:0]
  input  logic              s_tuser,    // mode
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [CHAR_W-1:0] m_tdata,    // out_char[7:0]
  output logic              m_tlast,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH + 1);

  logic [RADIX_W-1:0] radix;
  logic               lower_case;
  logic [FW_W-1:0]    field_width;
  logic [CHAR_W-1:0]  pad_char;

  state_t state, state_next;

  logic             neg;
  logic             sgn;
  logic [DIG_W-1:0] ndig;
  logic [CW-1:0]    pre;
  logic [CW-1:0]    rem_cnt;

  logic [RADIX_W-1:0] base;
  logic               in_neg;
  logic [VAL_W-1:0]   in_mag;
  logic [DIG_W-1:0]   ndig_inc;
  logic               div_start;
  logic [VAL_W-1:0]   div_dvd;
  div_out_t           div_res;
  lifo_ctrl_t         lctl;
  logic [CHAR_W-1:0]  lifo_top;
  logic [CHAR_W-1:0]  dig_ch;
  logic [CHAR_W-1:0]  emit_ch;
  logic               fin_div;
  logic               emit;

  logic [FW_W-1:0] fw_mag;
  logic [CW-1:0]   wid;
  logic [CW-1:0]   tlen;
  logic [CW-1:0]   total;
  logic [CW-1:0]   npad;

  rtf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .base     (base),
    .res      (div_res)
  );

  rtf_lifo u_lifo (
    .clk  (clk),
    .ctrl (lctl),
    .din  (dig_ch),
    .top  (lifo_top)
  );

  always_comb begin
    if (radix < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = radix;
    end
    in_neg   = s_tuser & s_tdata[VAL_W-1];
    in_mag   = in_neg ? (~s_tdata[VAL_W-1:0] + 1'b1) : s_tdata[VAL_W-1:0];
    ndig_inc = ndig + 1'b1;
    dig_ch   = digit_char(div_res.rem, lower_case);

    // -64 negates to 64, still fits the unsigned magnitude
    fw_mag = field_width[FW_W-1] ? (~field_width + 1'b1) : field_width;
    wid    = (int'(fw_mag) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(fw_mag);
    tlen   = CW'(ndig_inc) + CW'(neg);
    total  = (wid > tlen) ? wid : tlen;
    npad   = total - tlen;

    if (pre != '0) begin
      emit_ch = pad_char;
    end else if (sgn) begin
      emit_ch = CH_MINUS;
    end else if (ndig != '0) begin
      emit_ch = lifo_top;
    end else begin
      emit_ch = pad_char;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_dvd    = div_res.quot;
    lctl       = '0;
    fin_div    = 1'b0;
    emit       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          div_start  = 1'b1;
          div_dvd    = in_mag;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          lctl.push = 1'b1;
          if (div_res.quot == '0 || ndig_inc == DIG_W'(DIGITS_MAX)) begin
            fin_div    = 1'b1;
            state_next = ST_EMIT;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          emit = 1'b1;
          if (pre == '0 && !sgn && ndig != '0) begin
            lctl.pop = 1'b1;
          end
          if (rem_cnt == CW'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      radix       <= 6'd10;
      lower_case  <= 1'b0;
      field_width <= '0;
      pad_char    <= CH_SPACE;
      m_tvalid    <= 1'b0;
      neg         <= 1'b0;
      sgn         <= 1'b0;
      ndig        <= '0;
      pre         <= '0;
      rem_cnt     <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RADIX: radix       <= cfg_wdata[RADIX_W-1:0];
          REG_LOWER: lower_case  <= cfg_wdata[0];
          REG_WIDTH: field_width <= cfg_wdata[FW_W-1:0];
          REG_PAD:   pad_char    <= cfg_wdata;
          default: ;
        endcase
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == ST_IDLE && s_tvalid) begin
        neg  <= in_neg;
        ndig <= '0;
      end
      if (lctl.push) begin
        ndig <= ndig_inc;
      end
      if (fin_div) begin
        pre     <= field_width[FW_W-1] ? '0 : npad;
        rem_cnt <= total;
        sgn     <= neg;
      end
      if (emit) begin
        rem_cnt <= rem_cnt - 1'b1;
        if (pre != '0) begin
          pre <= pre - 1'b1;
        end else if (sgn) begin
          sgn <= 1'b0;
        end else if (ndig != '0) begin
          ndig <= ndig - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= emit_ch;
      m_tlast <= (rem_cnt == CW'(1));
    end
  end

  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> rem_cnt != '0)
    else $error("emit state with no characters left");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    emit && rem_cnt == CW'(1) |=> m_tvalid && m_tlast)
    else $error("final character not flagged");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> state == ST_DIV)
    else $error("divider finished outside the divide state");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> div_res.rem < base)
    else $error("remainder not below radix");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    lctl.pop |-> ndig != '0 && !lctl.push)
    else $error("digit stack popped while empty");

endmodule

// File: dv/tb_radix_integer_text_formatter.sv
// Self-checking testbench for the radix integer text formatter: directed table, then random.
module tb_radix_integer_text_formatter;
  import rtf_pkg::*;

  localparam int IDLE_LIMIT  = 20000;
  localparam int SETTLE      = 8;
  localparam int RAND_ITEMS  = 500;
  localparam int SHOW_ERRORS = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  typedef struct {
    int unsigned radix;
    bit          lower;
    int          width;
    logic [7:0]  pad;
    logic [31:0] value;
    bit          mode;
    string       text;
  } dir_row_t;

  logic              clk;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [31:0]       s_tdata   = '0;
  logic              s_tuser   = 1'b0;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [CHAR_W-1:0] m_tdata;
  logic              m_tlast;
  logic              cfg_we    = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [7:0]        cfg_wdata = '0;

  // Mirror of the config registers as last written.
  logic [RADIX_W-1:0]    cur_radix = 6'd10;
  logic                  cur_lower = 1'b0;
  logic signed [FW_W-1:0] cur_width = '0;
  logic [CHAR_W-1:0]     cur_pad   = CH_SPACE;

  text_char_t pending_chars[$];
  int         errors       = 0;
  int         quiet_cycles = 0;

  radix_integer_text_formatter u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Expected text of one number under the current settings.
  function automatic void format_number(input logic [31:0] value, input logic mode);
    logic [7:0]  body[$];
    logic [31:0] mag;
    text_char_t  c;
    int unsigned base, digit, span, total, npad;
    int          wv;
    bit          neg, left;
    base = cur_radix;
    if (base < RADIX_MIN) base = RADIX_MIN;
    if (base > RADIX_MAX) base = RADIX_MAX;
    neg = mode && value[31];
    mag = neg ? 32'd0 - value : value;
    do begin
      digit = mag % base;
      if (digit < 10) body.push_front(CH_ZERO + 8'(digit));
      else body.push_front((cur_lower ? CH_LOWER_BASE : CH_UPPER_BASE) + 8'(digit));
      mag = mag / base;
    end while (mag != 0);
    if (neg) body.push_front(CH_MINUS);
    wv = cur_width;
    left = wv < 0;
    span = left ? -wv : wv;
    if (span > MAX_WIDTH_DEF) span = MAX_WIDTH_DEF;
    total = (span > body.size()) ? span : body.size();
    npad = total - body.size();
    // positive width pads ahead of the sign, negative width pads at the tail
    for (int i = 0; i < npad; i++) begin
      if (left) body.push_back(cur_pad);
      else body.push_front(cur_pad);
    end
    for (int i = 0; i < total; i++) begin
      c.ch   = body[i];
      c.last = (i == total - 1);
      pending_chars.push_back(c);
    end
  endfunction

  function automatic void push_text(input string s);
    text_char_t c;
    for (int i = 0; i < s.len(); i++) begin
      c.ch   = s[i];
      c.last = (i == s.len() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  function automatic int unsigned pick_radix();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      r = $urandom_range(0, 28);
      return (r < 2) ? r : r + 35;  // 0, 1 or 37..63
    end
    if (r == 1) return 2;
    if (r == 2) return 36;
    return $urandom_range(2, 36);
  endfunction

  function automatic int pick_width();
    int w;
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: w = -64;
          1: w = -48;
          2: w = 48;
          default: w = 63;
        endcase
      end
      1: w = 0;
      default: begin
        w = $urandom_range(0, 127);
        if (w >= 64) w = w - 128;
      end
    endcase
    return w;
  endfunction

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 5))
          0: v = 32'h0000_0000;
          1: v = 32'h0000_0001;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'h8000_0000;
          4: v = 32'h7FFF_FFFF;
          default: v = 32'h8000_0001;
        endcase
      end
      1, 2: v = $urandom_range(0, 1000);
      3: v = 32'd0 - 32'($urandom_range(1, 1000));
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Bits above the register width carry junk; the block must drop them.
  task automatic write_reg(input logic [1:0] index, input logic [7:0] data,
                           input logic [7:0] mask);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= (data & mask) | (8'($urandom) & ~mask);
    @(posedge clk);
  endtask

  task automatic apply_setting(input int unsigned radix, input bit lower,
                               input int width, input logic [7:0] pad);
    write_reg(REG_RADIX, 8'(radix), 8'h3F);
    write_reg(REG_LOWER, 8'(lower), 8'h01);
    write_reg(REG_WIDTH, 8'(width), 8'h7F);
    write_reg(REG_PAD, pad, 8'hFF);
    cfg_we    <= 1'b0;
    cur_radix = 6'(radix);
    cur_lower = lower;
    cur_width = 7'(width);
    cur_pad   = pad;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic hold_off(input int unsigned cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Empty text means the expectation comes from format_number.
  task automatic send_number(input logic [31:0] value, input logic mode, input string text);
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= mode;
    do @(posedge clk); while (!s_tready);
    if (text.len() != 0) push_text(text);
    else format_number(value, mode);
  endtask

  // Receiver backpressure: stall density is redrawn whenever its random span runs out.
  int unsigned stall_level = 0;
  int unsigned stall_span  = 0;
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_level <= $urandom_range(0, 3);
      stall_span  <= $urandom_range(64, 512);
    end else begin
      stall_span <= stall_span - 1;
    end
    m_tready <= (stall_level == 0) || ($urandom_range(0, 3) >= stall_level);
  end

  always @(posedge clk) begin : char_check
    text_char_t want;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (m_tvalid && m_tready) begin
        if (pending_chars.size() == 0) begin
          errors++;
          if (errors <= SHOW_ERRORS)
            $display("unexpected char: got %h last %b", m_tdata, m_tlast);
        end else begin
          want = pending_chars.pop_front();
          if (m_tdata !== want.ch || m_tlast !== want.last) begin
            errors++;
            if (errors <= SHOW_ERRORS)
              $display("char mismatch: expected %h last %b, got %h last %b",
                       want.ch, want.last, m_tdata, m_tlast);
          end
        end
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < IDLE_LIMIT) @(posedge clk);
    $display("tb_radix_integer_text_formatter: done, errors");
    $finish;
  end

  initial begin : stim
    dir_row_t    rows[$];
    int unsigned sent, phase_len, burst_left;
    bit          gaps_on;
    // radix, lower, width, pad, value, mode, text
    rows.push_back('{10, 1'b0, 0, 8'h20, 32'h0000_0000, 1'b0, "0"});
    rows.push_back('{10, 1'b0, 0, 8'h20, 32'h0000_0000, 1'b1, "0"});
    rows.push_back('{10, 1'b0, 0, 8'h20, 32'hFFFF_FFFF, 1'b0, "4294967295"});
    rows.push_back('{10, 1'b0, 0, 8'h20, 32'hFFFF_FFFF, 1'b1, "-1"});
    rows.push_back('{10, 1'b0, 0, 8'h20, 32'h8000_0000, 1'b1, "-2147483648"});
    rows.push_back('{10, 1'b0, 0, 8'h20, 32'h8000_0000, 1'b0, "2147483648"});
    rows.push_back('{10, 1'b0, 0, 8'h20, 32'h7FFF_FFFF, 1'b1, "2147483647"});
    rows.push_back('{10, 1'b0, 2, 8'h20, 32'd12345, 1'b0, "12345"});
    rows.push_back('{16, 1'b0, 0, 8'h20, 32'hDEAD_BEEF, 1'b0, "DEADBEEF"});
    rows.push_back('{16, 1'b1, 0, 8'h20, 32'hDEAD_BEEF, 1'b0, "deadbeef"});
    rows.push_back('{16, 1'b1, 0, 8'h20, 32'hDEAD_BEEF, 1'b1, "-21524111"});
    rows.push_back('{36, 1'b0, 0, 8'h20, 32'hFFFF_FFFF, 1'b0, "1Z141Z3"});
    rows.push_back('{36, 1'b1, 0, 8'h20, 32'hFFFF_FFFF, 1'b0, "1z141z3"});
    rows.push_back('{2, 1'b0, 0, 8'h20, 32'hFFFF_FFFF, 1'b0,
                     "11111111111111111111111111111111"});
    rows.push_back('{2, 1'b0, 0, 8'h20, 32'h8000_0000, 1'b1, ""});
    rows.push_back('{10, 1'b0, 8, 8'h2A, 32'd42, 1'b0, "******42"});
    rows.push_back('{10, 1'b0, -8, 8'h2A, 32'd42, 1'b0, "42******"});
    rows.push_back('{10, 1'b0, 5, 8'h30, 32'hFFFF_FFF9, 1'b1, "000-7"});
    rows.push_back('{10, 1'b0, -5, 8'h30, 32'hFFFF_FFF9, 1'b1, "-7000"});
    rows.push_back('{10, 1'b0, 48, 8'h20, 32'h0000_0000, 1'b0, ""});
    rows.push_back('{10, 1'b0, 63, 8'h2E, 32'h0000_0001, 1'b0, ""});
    rows.push_back('{2, 1'b0, -64, 8'h5F, 32'h8000_0000, 1'b1, ""});
    rows.push_back('{10, 1'b0, 3, 8'h00, 32'd5, 1'b0, ""});
    rows.push_back('{0, 1'b0, 0, 8'h20, 32'd5, 1'b0, "101"});
    rows.push_back('{1, 1'b0, 0, 8'h20, 32'd5, 1'b0, "101"});
    rows.push_back('{37, 1'b0, 0, 8'h20, 32'd35, 1'b0, "Z"});
    rows.push_back('{63, 1'b1, 0, 8'h20, 32'd36, 1'b0, "10"});

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first rows run on the reset values of the registers
    foreach (rows[i]) begin
      if (rows[i].radix != cur_radix || rows[i].lower != cur_lower ||
          rows[i].width != cur_width || rows[i].pad != cur_pad) begin
        drain();
        apply_setting(rows[i].radix, rows[i].lower, rows[i].width, rows[i].pad);
      end
      send_number(rows[i].value, rows[i].mode, rows[i].text);
    end

    sent       = 0;
    burst_left = 0;
    while (sent < RAND_ITEMS) begin
      drain();
      apply_setting(pick_radix(), bit'($urandom_range(0, 1)), pick_width(), 8'($urandom));
      gaps_on   = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(20, 60);
      repeat (phase_len) begin
        if (gaps_on && burst_left == 0) begin
          burst_left = $urandom_range(1, 8);
          // long gaps leave the block idle, short ones land mid-conversion
          hold_off($urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(20, 600));
        end
        send_number(pick_value(), 1'($urandom_range(0, 1)), "");
        if (burst_left != 0) burst_left--;
        sent++;
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("tb_radix_integer_text_formatter: done, clean");
    else $display("tb_radix_integer_text_formatter: done, errors");
    $finish;
  end

endmodule
